// ===== sv/dwpid_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the dual wheel PID speed controller.
package dwpid_pkg;

   localparam int TGT_W   = 26;
   localparam int PWM_W   = 16;
   localparam int SCL_W   = 10;
   localparam int GAIN_W  = 24;
   localparam int CNT_W   = 16;
   localparam int ERR_W   = 28;
   localparam int DIFF_W  = 29;
   localparam int INTEG_W = 48;
   localparam int MUL_A_W = 32;
   localparam int PROD_W  = MUL_A_W + GAIN_W;
   localparam int ACC_W   = 74;
   localparam int OUT_W   = 35;
   localparam int IDX_W   = 3;
   localparam int ELAP_W  = 16;

   localparam logic [PWM_W-1:0] LEVEL_RESET = 16'd7500;
   localparam logic [PWM_W-1:0] PWM_MAX_RESET = 16'd10000;
   localparam logic [SCL_W-1:0] SCALE_RESET = 10'd1;
   localparam logic [GAIN_W-1:0] GAIN_P_RESET = 24'd2621440;
   localparam logic [GAIN_W-1:0] GAIN_I_RESET = 24'd524;
   localparam logic [GAIN_W-1:0] GAIN_D_RESET = 24'd2621;

   localparam logic [IDX_W-1:0] REG_TARGET = 3'd0;
   localparam logic [IDX_W-1:0] REG_PWM_MAX = 3'd1;
   localparam logic [IDX_W-1:0] REG_SCALE = 3'd2;
   localparam logic [IDX_W-1:0] REG_GAIN_P = 3'd3;
   localparam logic [IDX_W-1:0] REG_GAIN_I = 3'd4;
   localparam logic [IDX_W-1:0] REG_GAIN_D = 3'd5;

   localparam logic [1:0] OP_EDGES = 2'd0;
   localparam logic [1:0] OP_WINDOW = 2'd1;
   localparam logic [1:0] OP_UPDATE = 2'd2;
   localparam logic [1:0] OP_CLEAR = 2'd3;

   typedef enum logic [3:0] {
      S_IDLE, S_WIN_A, S_WIN_B, S_WIN_C, S_ERR, S_MI, S_INT, S_DST,
      S_PT, S_IL, S_IH, S_DW, S_D, S_OUT, S_FIN
   } state_type;

endpackage

// ===== sv/dwpid_mul.sv =====
`timescale 1ns / 1ps
// Shared unsigned multiplier with registered product.
module dwpid_mul
   import dwpid_pkg::*;
(
   input  logic              clock,
   input  logic [MUL_A_W-1:0] mul_a,
   input  logic [GAIN_W-1:0]  mul_b,
   output logic [PROD_W-1:0]  prod_ff
);

   logic [PROD_W-1:0] prod_in;

   assign prod_in = PROD_W'(mul_a) * PROD_W'(mul_b);

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
   end

endmodule

// ===== sv/dwpid_div.sv =====
`timescale 1ns / 1ps
// Restoring serial divider, one quotient bit per cycle.
module dwpid_div
   import dwpid_pkg::*;
#(
   parameter int NUM_W = 36
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [NUM_W-1:0]  num,
   input  logic [ELAP_W-1:0] den,
   output logic              busy,
   output logic [NUM_W-1:0]  quo
);

   localparam int CW = $clog2(NUM_W + 1);

   logic [ELAP_W-1:0] rem_ff, rem_in;
   logic [NUM_W-1:0]  quo_ff, quo_in;
   logic [ELAP_W-1:0] den_ff, den_in;
   logic [CW-1:0]     cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic [ELAP_W:0]   trial;
   logic              fits;

   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      den_in  = den_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      if (start) begin
         rem_in  = '0;
         quo_in  = num;
         den_in  = den;
         cnt_in  = CW'(NUM_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? ELAP_W'(trial - {1'b0, den_ff}) : trial[ELAP_W-1:0];
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CW'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      den_ff <= den_in;
   end

   assign busy = busy_ff;
   assign quo  = quo_ff;

endmodule

// ===== sv/dual_wheel_pid_speed_control_core.sv =====
`timescale 1ns / 1ps
// Dual wheel PID speed controller: sequencer, state and configuration.
// Opcodes 0 and 3 go straight to the finish state; opcode 1 first passes S_WIN_A, S_WIN_B and S_WIN_C.
// Opcode 2 runs the control steps once per wheel, its time set by the serial derivative divider
// (NUM_W = 56 - GAIN_FRAC_BITS), one quotient bit per cycle, which zero elapsed time does not start.
// One item at a time; the next transfer is taken the cycle after the result register loads.
// Synchronous reset restores all configuration, clears the loop state and sets levels to 7500.
module dual_wheel_pid_speed_control_core
   import dwpid_pkg::*;
#(
   parameter int GAIN_FRAC_BITS = 20
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  logic [1:0]        req_opcode,
   input  logic              req_edge_a,
   input  logic              req_edge_b,
   input  logic [ELAP_W-1:0] req_elapsed_ms,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic [PWM_W-1:0]  rsp_duty_a,
   output logic [PWM_W-1:0]  rsp_duty_b,
   output logic [TGT_W-1:0]  rsp_rate_a,
   output logic [TGT_W-1:0]  rsp_rate_b,
   input  logic              csr_wr_en,
   input  logic [IDX_W-1:0]  csr_index,
   input  logic [TGT_W-1:0]  csr_wdata
);

   localparam int F = GAIN_FRAC_BITS;
   localparam int NUM_W = PROD_W - F;

   state_type state_ff, state_in;

   logic [TGT_W-1:0]  target_ff;
   logic [PWM_W-1:0]  pwm_max_ff;
   logic [SCL_W-1:0]  scale_ff;
   logic [GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;

   logic [CNT_W-1:0]         count_ff [2];
   logic [CNT_W-1:0]         count_in [2];
   logic [TGT_W-1:0]         speed_ff [2];
   logic [TGT_W-1:0]         speed_in [2];
   logic signed [INTEG_W-1:0] integ_ff [2];
   logic signed [INTEG_W-1:0] integ_in [2];
   logic signed [ERR_W-1:0]  prev_ff [2];
   logic signed [ERR_W-1:0]  prev_in [2];
   logic [PWM_W-1:0]         level_ff [2];
   logic [PWM_W-1:0]         level_in [2];

   logic                     wsel_ff, wsel_in;
   logic [ELAP_W-1:0]        elapsed_ff, elapsed_in;
   logic signed [ERR_W-1:0]  e_ff, e_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic [PROD_W-1:0]        lo_ff, lo_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PWM_W-1:0]  duty_a_ff, duty_b_ff;
   logic [TGT_W-1:0]  rate_a_ff, rate_b_ff;

   logic [MUL_A_W-1:0] mul_a;
   logic [GAIN_W-1:0]  mul_b;
   logic [PROD_W-1:0]  prod;
   logic               div_start;
   logic               div_busy;
   logic [NUM_W-1:0]   quo;

   logic               accept, out_free, load_rsp;
   logic [ERR_W-1:0]   e_mag;
   logic [DIFF_W-1:0]  diff_mag;
   logic [INTEG_W-1:0] integ_mag;
   logic signed [INTEG_W+1:0] isum;
   logic [ACC_W-1:0]   acc_mag, acc_shr;
   logic [32:0]        out_mag;
   logic signed [OUT_W-1:0] out_s, nl;

   function automatic logic signed [ACC_W-1:0] apply_sign(logic [ACC_W-1:0] m, logic neg);
      apply_sign = neg ? -$signed(m) : $signed(m);
   endfunction

   assign accept   = req_valid && !req_stall;
   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign load_rsp = (state_ff == S_FIN) && out_free;
   assign req_stall = (state_ff != S_IDLE);

   assign e_mag     = e_ff[ERR_W-1] ? ERR_W'(-e_ff) : e_ff;
   assign diff_mag  = diff_ff[DIFF_W-1] ? DIFF_W'(-diff_ff) : diff_ff;
   assign integ_mag = integ_ff[wsel_ff][INTEG_W-1] ? INTEG_W'(-integ_ff[wsel_ff])
                                                  : integ_ff[wsel_ff];
   assign isum = {{2{integ_ff[wsel_ff][INTEG_W-1]}}, integ_ff[wsel_ff]}
               + (e_ff[ERR_W-1] ? -$signed({7'b0, prod[42:0]})
                                : $signed({7'b0, prod[42:0]}));
   assign acc_mag = acc_ff[ACC_W-1] ? ACC_W'(-acc_ff) : acc_ff;
   assign acc_shr = acc_mag >> F;
   assign out_mag = (acc_shr > (ACC_W'(1) << 32)) ? {1'b1, 32'b0} : acc_shr[32:0];
   assign out_s   = acc_ff[ACC_W-1] ? -$signed({2'b0, out_mag}) : $signed({2'b0, out_mag});
   assign nl      = $signed({19'b0, level_ff[wsel_ff]}) + out_s;

   dwpid_mul u_mul (
      .clock   (clock),
      .mul_a   (mul_a),
      .mul_b   (mul_b),
      .prod_ff (prod)
   );

   dwpid_div #(.NUM_W(NUM_W)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (prod[PROD_W-1:F]),
      .den   (elapsed_ff),
      .busy  (div_busy),
      .quo   (quo)
   );

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               priority if (req_opcode == OP_WINDOW) state_in = S_WIN_A;
               else if (req_opcode == OP_UPDATE) state_in = S_ERR;
               else state_in = S_FIN;
            end
         end
         S_WIN_A: state_in = S_WIN_B;
         S_WIN_B: state_in = S_WIN_C;
         S_WIN_C: state_in = S_FIN;
         S_ERR:   state_in = S_MI;
         S_MI:    state_in = S_INT;
         S_INT:   state_in = S_DST;
         S_DST:   state_in = S_PT;
         S_PT:    state_in = S_IL;
         S_IL:    state_in = S_IH;
         S_IH:    state_in = S_DW;
         S_DW:    state_in = div_busy ? S_DW : S_D;
         S_D:     state_in = S_OUT;
         S_OUT:   state_in = wsel_ff ? S_ERR : S_FIN;
         S_FIN:   state_in = out_free ? S_IDLE : S_FIN;
         default: state_in = S_IDLE;
      endcase
   end

   always_comb begin
      count_in = count_ff;
      speed_in = speed_ff;
      integ_in = integ_ff;
      prev_in  = prev_ff;
      level_in = level_ff;
      wsel_in  = wsel_ff;
      elapsed_in = elapsed_ff;
      e_in     = e_ff;
      diff_in  = diff_ff;
      acc_in   = acc_ff;
      lo_in    = lo_ff;
      mul_a    = '0;
      mul_b    = '0;
      div_start = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               elapsed_in = req_elapsed_ms;
               wsel_in    = 1'b1;
               if (req_opcode == OP_EDGES) begin
                  if (req_edge_a && count_ff[0] != '1) count_in[0] = count_ff[0] + 1'b1;
                  if (req_edge_b && count_ff[1] != '1) count_in[1] = count_ff[1] + 1'b1;
               end
               if (req_opcode == OP_CLEAR) begin
                  integ_in[0] = '0;
                  integ_in[1] = '0;
                  prev_in[0]  = '0;
                  prev_in[1]  = '0;
               end
            end
         end
         S_WIN_A: begin
            mul_a = MUL_A_W'(count_ff[0]);
            mul_b = GAIN_W'(scale_ff);
         end
         S_WIN_B: begin
            speed_in[0] = prod[TGT_W-1:0];
            mul_a = MUL_A_W'(count_ff[1]);
            mul_b = GAIN_W'(scale_ff);
         end
         S_WIN_C: begin
            speed_in[1] = prod[TGT_W-1:0];
            count_in[0] = '0;
            count_in[1] = '0;
         end
         S_ERR: begin
            e_in = $signed(ERR_W'({2'b0, target_ff} - {2'b0, speed_ff[wsel_ff]}));
            diff_in = $signed({e_in[ERR_W-1], e_in})
                    - $signed({prev_ff[wsel_ff][ERR_W-1], prev_ff[wsel_ff]});
         end
         S_MI: begin
            mul_a = MUL_A_W'(e_mag);
            mul_b = GAIN_W'(elapsed_ff);
         end
         S_INT: begin
            priority if (isum > $signed({3'b0, {(INTEG_W-1){1'b1}}}))
               integ_in[wsel_ff] = {1'b0, {(INTEG_W-1){1'b1}}};
            else if (isum < -$signed({3'b0, {(INTEG_W-1){1'b1}}}) - 1)
               integ_in[wsel_ff] = {1'b1, {(INTEG_W-1){1'b0}}};
            else
               integ_in[wsel_ff] = isum[INTEG_W-1:0];
            mul_a = MUL_A_W'(diff_mag);
            mul_b = gain_d_ff;
         end
         S_DST: begin
            div_start = (elapsed_ff != '0);
            mul_a = MUL_A_W'(e_mag);
            mul_b = gain_p_ff;
         end
         S_PT: begin
            acc_in = apply_sign(ACC_W'(prod), e_ff[ERR_W-1]);
            mul_a = integ_mag[31:0];
            mul_b = gain_i_ff;
         end
         S_IL: begin
            lo_in = prod;
            mul_a = MUL_A_W'(integ_mag[INTEG_W-1:32]);
            mul_b = gain_i_ff;
         end
         S_IH: begin
            acc_in = acc_ff + apply_sign(ACC_W'(lo_ff) + (ACC_W'(prod) << 32),
                                         integ_ff[wsel_ff][INTEG_W-1]);
         end
         S_DW: ;
         S_D: begin
            if (elapsed_ff != '0)
               acc_in = acc_ff + apply_sign(ACC_W'({quo, {F{1'b0}}}),
                                            diff_ff[DIFF_W-1]);
         end
         S_OUT: begin
            priority if (nl < 0) level_in[wsel_ff] = '0;
            else if (nl > $signed({19'b0, pwm_max_ff})) level_in[wsel_ff] = pwm_max_ff;
            else level_in[wsel_ff] = nl[PWM_W-1:0];
            prev_in[wsel_ff] = e_ff;
            wsel_in = 1'b0;
         end
         S_FIN: ;
         default: ;
      endcase
   end

   assign rsp_valid_in = load_rsp ? 1'b1 : (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         target_ff    <= '0;
         pwm_max_ff   <= PWM_MAX_RESET;
         scale_ff     <= SCALE_RESET;
         gain_p_ff    <= GAIN_P_RESET;
         gain_i_ff    <= GAIN_I_RESET;
         gain_d_ff    <= GAIN_D_RESET;
         for (int i = 0; i < 2; i++) begin
            count_ff[i] <= '0;
            speed_ff[i] <= '0;
            integ_ff[i] <= '0;
            prev_ff[i]  <= '0;
            level_ff[i] <= LEVEL_RESET;
         end
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         count_ff     <= count_in;
         speed_ff     <= speed_in;
         integ_ff     <= integ_in;
         prev_ff      <= prev_in;
         level_ff     <= level_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               REG_TARGET:  target_ff  <= csr_wdata;
               REG_PWM_MAX: pwm_max_ff <= csr_wdata[PWM_W-1:0];
               REG_SCALE:   scale_ff   <= csr_wdata[SCL_W-1:0];
               REG_GAIN_P:  gain_p_ff  <= csr_wdata[GAIN_W-1:0];
               REG_GAIN_I:  gain_i_ff  <= csr_wdata[GAIN_W-1:0];
               REG_GAIN_D:  gain_d_ff  <= csr_wdata[GAIN_W-1:0];
               default: ;
            endcase
         end
      end
      wsel_ff    <= wsel_in;
      elapsed_ff <= elapsed_in;
      e_ff       <= e_in;
      diff_ff    <= diff_in;
      acc_ff     <= acc_in;
      lo_ff      <= lo_in;
      if (load_rsp) begin
         duty_a_ff <= level_ff[0];
         duty_b_ff <= level_ff[1];
         rate_a_ff <= speed_ff[0];
         rate_b_ff <= speed_ff[1];
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_duty_a = duty_a_ff;
   assign rsp_duty_b = duty_b_ff;
   assign rsp_rate_a = rate_a_ff;
   assign rsp_rate_b = rate_b_ff;

   a_fin_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FIN && !out_free) |=> (state_ff == S_FIN))
      else $error("result dropped while output register busy");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FIN))
      else $error("result raised outside finish state");

   a_div_in_pid: assert property (@(posedge clock) disable iff (reset)
      div_busy |-> (state_ff == S_PT || state_ff == S_IL || state_ff == S_IH ||
                    state_ff == S_DW))
      else $error("divider running outside control step");

endmodule

// ===== bench/dual_wheel_pid_speed_control_core_tb.sv =====
`timescale 1ns / 1ps
// Testbench for the dual wheel PID speed controller core, with its own speed and duty predictor.
module dual_wheel_pid_speed_control_core_tb;
   import dwpid_pkg::*;

   localparam int FRAC = 20;
   localparam int IDLE_LIMIT = 5000;

   typedef struct {
      logic [PWM_W-1:0] duty_a;
      logic [PWM_W-1:0] duty_b;
      logic [TGT_W-1:0] rate_a;
      logic [TGT_W-1:0] rate_b;
   } wheel_status_type;

   class wheel_scoreboard;
      logic [TGT_W-1:0]  target;
      logic [PWM_W-1:0]  pwm_max;
      logic [SCL_W-1:0]  scale;
      logic [GAIN_W-1:0] gain_p, gain_i, gain_d;
      logic [CNT_W-1:0]  count_a, count_b;
      logic [TGT_W-1:0]  speed_a, speed_b;
      longint            integ_a, integ_b, prev_a, prev_b;
      longint            level_a, level_b;
      wheel_status_type  status_q[$];
      int                errors;
      int                n_ops[4];
      int                n_checked;

      function new();
         target = '0; pwm_max = PWM_MAX_RESET; scale = SCALE_RESET;
         gain_p = GAIN_P_RESET; gain_i = GAIN_I_RESET; gain_d = GAIN_D_RESET;
         count_a = '0; count_b = '0; speed_a = '0; speed_b = '0;
         integ_a = 0; integ_b = 0; prev_a = 0; prev_b = 0;
         level_a = LEVEL_RESET; level_b = LEVEL_RESET;
         errors = 0; n_checked = 0;
         foreach (n_ops[i]) n_ops[i] = 0;
      endfunction

      function void set_reg(logic [IDX_W-1:0] idx, logic [TGT_W-1:0] val);
         case (idx)
            REG_TARGET:  target = val;
            REG_PWM_MAX: pwm_max = val[PWM_W-1:0];
            REG_SCALE:   scale = val[SCL_W-1:0];
            REG_GAIN_P:  gain_p = val[GAIN_W-1:0];
            REG_GAIN_I:  gain_i = val[GAIN_W-1:0];
            REG_GAIN_D:  gain_d = val[GAIN_W-1:0];
            default: ;
         endcase
      endfunction

      function void pid_step(input logic [TGT_W-1:0] spd, inout longint integ,
                             inout longint prev, inout longint lvl, input longint el);
         longint e, s, diff, d, o, nl;
         longint imax, imin;
         logic [63:0] mag, q;
         logic signed [127:0] te, ti, td, gp, gi, acc, am;
         logic [127:0] qm;
         imax = (longint'(1) <<< 47) - 1;
         imin = -imax - 1;
         e = longint'(target) - longint'(spd);
         s = integ + e * el;
         if (s > imax) s = imax;
         if (s < imin) s = imin;
         integ = s;
         d = 0;
         if (el != 0) begin
            diff = e - prev;
            mag = diff < 0 ? -diff : diff;
            q = (mag * gain_d) / (el << FRAC);
            d = diff < 0 ? -longint'(q) : longint'(q);
         end
         te = e; ti = integ; td = d;
         gp = gain_p; gi = gain_i;
         acc = te * gp + ti * gi + (td <<< FRAC);
         am = acc < 0 ? -acc : acc;
         qm = am >> FRAC;
         if (qm > (128'd1 << 32)) qm = 128'd1 << 32;
         o = acc < 0 ? -longint'(qm[63:0]) : longint'(qm[63:0]);
         nl = lvl + o;
         if (nl < 0) nl = 0;
         if (nl > longint'(pwm_max)) nl = pwm_max;
         lvl = nl;
         prev = e;
      endfunction

      function void note_item(logic [1:0] op, logic ea, logic eb, logic [ELAP_W-1:0] el);
         wheel_status_type r;
         logic [31:0] p;
         n_ops[op]++;
         case (op)
            OP_EDGES: begin
               if (ea && count_a != '1) count_a++;
               if (eb && count_b != '1) count_b++;
            end
            OP_WINDOW: begin
               p = count_a * scale; speed_a = p[TGT_W-1:0];
               p = count_b * scale; speed_b = p[TGT_W-1:0];
               count_a = '0; count_b = '0;
            end
            OP_UPDATE: begin
               pid_step(speed_b, integ_b, prev_b, level_b, longint'(el));
               pid_step(speed_a, integ_a, prev_a, level_a, longint'(el));
            end
            default: begin
               integ_a = 0; integ_b = 0; prev_a = 0; prev_b = 0;
            end
         endcase
         r.duty_a = level_a[PWM_W-1:0];
         r.duty_b = level_b[PWM_W-1:0];
         r.rate_a = speed_a;
         r.rate_b = speed_b;
         status_q.push_back(r);
      endfunction

      function void check_status(wheel_status_type got);
         wheel_status_type x;
         if (status_q.size() == 0) begin
            $error("unexpected result transfer");
            errors++;
            return;
         end
         x = status_q.pop_front();
         n_checked++;
         if (got.duty_a !== x.duty_a) begin
            $error("duty_a expected %0d actual %0d", x.duty_a, got.duty_a); errors++;
         end
         if (got.duty_b !== x.duty_b) begin
            $error("duty_b expected %0d actual %0d", x.duty_b, got.duty_b); errors++;
         end
         if (got.rate_a !== x.rate_a) begin
            $error("rate_a expected %0d actual %0d", x.rate_a, got.rate_a); errors++;
         end
         if (got.rate_b !== x.rate_b) begin
            $error("rate_b expected %0d actual %0d", x.rate_b, got.rate_b); errors++;
         end
      endfunction
   endclass

   logic              clock = 1'b0;
   logic              reset = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_stall;
   logic [1:0]        req_opcode = OP_EDGES;
   logic              req_edge_a = 1'b0;
   logic              req_edge_b = 1'b0;
   logic [ELAP_W-1:0] req_elapsed_ms = '0;
   logic              rsp_valid;
   logic              rsp_stall = 1'b0;
   logic [PWM_W-1:0]  rsp_duty_a, rsp_duty_b;
   logic [TGT_W-1:0]  rsp_rate_a, rsp_rate_b;
   logic              csr_wr_en = 1'b0;
   logic [IDX_W-1:0]  csr_index = REG_TARGET;
   logic [TGT_W-1:0]  csr_wdata = '0;

   wheel_scoreboard status_sb = new();
   bit quiet = 1'b0;
   bit hold_req = 1'b0;
   int idle_cycles = 0;

   always #5 clock = ~clock;

   dual_wheel_pid_speed_control_core i_dut (.*);

   always @(posedge clock) begin
      wheel_status_type got;
      if (!reset && rsp_valid && !rsp_stall) begin
         got.duty_a = rsp_duty_a; got.duty_b = rsp_duty_b;
         got.rate_a = rsp_rate_a; got.rate_b = rsp_rate_b;
         status_sb.check_status(got);
      end
      if ((rsp_valid && !rsp_stall) || (req_valid && !req_stall) || reset)
         idle_cycles <= 0;
      else if (idle_cycles >= IDLE_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", IDLE_LIMIT);
         $display("DONE: errors detected");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   // receiver stall: random, or one long hold-off on request
   initial begin
      forever begin
         @(negedge clock);
         if (hold_req) begin
            rsp_stall = 1'b1;
            repeat (300) @(negedge clock);
            hold_req = 1'b0;
         end
         rsp_stall = !quiet && ($urandom_range(0, 99) < 25);
      end
   end

   task automatic send_item(logic [1:0] op, logic ea, logic eb, logic [ELAP_W-1:0] el);
      if (!quiet && $urandom_range(0, 99) < 25) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat ($urandom_range(0, 3)) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_opcode = op; req_edge_a = ea; req_edge_b = eb; req_elapsed_ms = el;
      do @(posedge clock); while (req_stall);
      status_sb.note_item(op, ea, eb, el);
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid = 1'b0;
      while (status_sb.status_q.size() != 0) @(posedge clock);
      repeat (120) @(posedge clock);
   endtask

   task automatic csr_write(logic [IDX_W-1:0] idx, logic [TGT_W-1:0] val);
      @(negedge clock);
      csr_wr_en = 1'b1; csr_index = idx; csr_wdata = val;
      status_sb.set_reg(idx, val);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   task automatic set_all(logic [TGT_W-1:0] tg, logic [PWM_W-1:0] pm, logic [SCL_W-1:0] sc,
                          logic [GAIN_W-1:0] kp, logic [GAIN_W-1:0] ki,
                          logic [GAIN_W-1:0] kd);
      csr_write(REG_TARGET, tg);
      csr_write(REG_PWM_MAX, pm);
      csr_write(REG_SCALE, sc);
      csr_write(REG_GAIN_P, kp);
      csr_write(REG_GAIN_I, ki);
      csr_write(REG_GAIN_D, kd);
   endtask

   function automatic logic [ELAP_W-1:0] rand_elapsed();
      int r;
      r = $urandom_range(0, 99);
      if (r < 5) return '0;
      if (r < 10) return '1;
      if (r < 25) return ELAP_W'($urandom());
      return ELAP_W'($urandom_range(1, 200));
   endfunction

   // a measurement window followed by a control step, with occasional noise
   task automatic rand_cycle();
      int n;
      n = $urandom_range(0, 30);
      repeat (n) send_item(OP_EDGES, 1'($urandom()), 1'($urandom()), ELAP_W'($urandom()));
      send_item(OP_WINDOW, 1'($urandom()), 1'($urandom()), ELAP_W'($urandom()));
      send_item(OP_UPDATE, 1'($urandom()), 1'($urandom()), rand_elapsed());
      if ($urandom_range(0, 99) < 10)
         send_item(OP_CLEAR, 1'($urandom()), 1'($urandom()), ELAP_W'($urandom()));
      if ($urandom_range(0, 99) < 20)
         send_item(2'($urandom_range(0, 3)), 1'($urandom()), 1'($urandom()), rand_elapsed());
   endtask

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed, reset configuration
      send_item(OP_EDGES, 1'b1, 1'b0, 16'hFFFF);
      send_item(OP_EDGES, 1'b0, 1'b1, 16'h0000);
      send_item(OP_EDGES, 1'b1, 1'b1, 16'h5A5A);
      send_item(OP_EDGES, 1'b0, 1'b0, 16'hA5A5);
      send_item(OP_WINDOW, 1'b1, 1'b1, 16'hFFFF);
      send_item(OP_UPDATE, 1'b1, 1'b1, 16'd0);
      send_item(OP_UPDATE, 1'b0, 1'b0, 16'd1);
      send_item(OP_UPDATE, 1'b0, 1'b1, 16'hFFFF);
      send_item(OP_CLEAR, 1'b1, 1'b0, 16'hFFFF);
      send_item(OP_UPDATE, 1'b0, 1'b0, 16'd10);
      drain();

      // extremes: integral and output saturation, lowered pwm_max
      set_all('1, 16'hFFFF, 10'd1000, '1, '1, '1);
      repeat (3) send_item(OP_EDGES, 1'b1, 1'b0, 16'd0);
      send_item(OP_WINDOW, 1'b0, 1'b0, 16'd0);
      repeat (40) send_item(OP_UPDATE, 1'b0, 1'b0, 16'hFFFF);
      drain();
      csr_write(REG_PWM_MAX, 26'd1);
      send_item(OP_EDGES, 1'b0, 1'b0, 16'd0);
      send_item(OP_UPDATE, 1'b0, 1'b0, 16'd0);
      send_item(OP_CLEAR, 1'b0, 1'b0, 16'd0);
      drain();

      // zero scale and zero pwm_max taken literally
      set_all(26'd1234, 16'd0, 10'd0, 24'd0, 24'd0, 24'd0);
      repeat (5) send_item(OP_EDGES, 1'b1, 1'b1, 16'd3);
      send_item(OP_WINDOW, 1'b0, 1'b0, 16'd0);
      send_item(OP_UPDATE, 1'b0, 1'b0, 16'd7);
      drain();

      // random phases over a spread of settings
      for (int ph = 0; ph < 6; ph++) begin
         case (ph)
            0: set_all(26'd2000, 16'd10000, 10'd10, GAIN_P_RESET, GAIN_I_RESET, GAIN_D_RESET);
            1: set_all(TGT_W'($urandom_range(0, 60000)), PWM_W'($urandom_range(1, 65535)),
                       SCL_W'($urandom_range(1, 1000)), GAIN_W'($urandom()),
                       GAIN_W'($urandom_range(0, 4000)), GAIN_W'($urandom()));
            2: set_all('1, 16'hFFFF, 10'd1000, '1, '1, '1);
            3: set_all(26'd0, 16'd1, 10'd1, 24'd0, 24'd0, 24'd0);
            default: set_all(TGT_W'($urandom()), PWM_W'($urandom_range(1, 65535)),
                             SCL_W'($urandom_range(1, 1000)), GAIN_W'($urandom()),
                             GAIN_W'($urandom()), GAIN_W'($urandom()));
         endcase
         if (ph == 1) quiet = 1'b1;
         if (ph == 2) hold_req = 1'b1;
         repeat (4) rand_cycle();
         quiet = 1'b0;
         repeat (2) rand_cycle();
         drain();
      end

      drain();
      $display("covered %0d edge, %0d window, %0d update and %0d clear items; %0d results checked",
               status_sb.n_ops[OP_EDGES], status_sb.n_ops[OP_WINDOW],
               status_sb.n_ops[OP_UPDATE], status_sb.n_ops[OP_CLEAR], status_sb.n_checked);
      $display("settings spanned reset, extreme, zero and random registers");
      if (status_sb.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== sim.f =====
sv/dwpid_pkg.sv
sv/dwpid_mul.sv
sv/dwpid_div.sv
sv/dual_wheel_pid_speed_control_core.sv
bench/dual_wheel_pid_speed_control_core_tb.sv
